// ===== src/key_matrix_row_debouncer_defines.svh =====
// Assertion macros for the key matrix row debouncer.
// Expects clk and rst_n in the scope of every use.
`ifndef KEY_MATRIX_ROW_DEBOUNCER_DEFINES_SVH
`define KEY_MATRIX_ROW_DEBOUNCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KMRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KMRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/kmrd_pkg.sv =====
// Shared constants, types and mask functions of the key matrix row debouncer.
// No dependencies.
`default_nettype none

package kmrd_pkg;

    localparam int MAX_ROWS    = 32;
    localparam int MAX_COLUMNS = 32;

    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int ROWCNT_W  = $clog2(MAX_ROWS + 1);
    localparam int HIST_W    = 8;
    localparam int SHIFT_W   = 4;
    localparam int TIME_W    = 16;
    localparam int LEN_W     = 4;
    localparam int COUNT_W   = 6;
    localparam int FIELD_ROW_W  = 5;
    localparam int FIELD_KEYS_W = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE_LENGTH = 2'd0,
        CFG_ROWS_IN_USE     = 2'd1,
        CFG_COLUMNS_IN_USE  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic               sampled;
        logic [SHIFT_W-1:0] shifts;
        logic [HIST_W-1:0]  lmask;
    } lane_ctrl_t;

    typedef struct packed {
        logic [HIST_W-1:0] history;
        logic              key;
        logic              bounce;
    } lane_res_t;

    typedef struct packed {
        logic [MAX_COLUMNS-1:0][HIST_W-1:0] history;
        logic [MAX_COLUMNS-1:0]             keys;
        logic [TIME_W-1:0]                  stamp;
    } row_word_t;

    function automatic logic [HIST_W-1:0] len_mask(input logic [LEN_W-1:0] n);
        int                eff;
        logic [HIST_W-1:0] m;
        eff = int'(n);
        if (eff < 1) eff = 1;
        if (eff > HIST_W) eff = HIST_W;
        for (int i = 0; i < HIST_W; i++)
        begin
            m[i] = (i < eff);
        end
        return m;
    endfunction

    function automatic logic [MAX_COLUMNS-1:0] col_mask(input logic [COUNT_W-1:0] n);
        int                     eff;
        logic [MAX_COLUMNS-1:0] m;
        eff = int'(n);
        if (eff < 1) eff = 1;
        if (eff > MAX_COLUMNS) eff = MAX_COLUMNS;
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            m[i] = (i < eff);
        end
        return m;
    endfunction

    function automatic logic [ROWCNT_W-1:0] eff_rows(input logic [COUNT_W-1:0] n);
        int eff;
        eff = int'(n);
        if (eff < 1) eff = 1;
        if (eff > MAX_ROWS) eff = MAX_ROWS;
        return ROWCNT_W'(eff);
    endfunction

endpackage

`default_nettype wire

// ===== src/key_matrix_row_debouncer.sv =====
// Top level of the key matrix row debouncer: config registers, row scan,
// column lanes, merge and output register. Depends on kmrd_pkg, kmrd_lane,
// kmrd_merge, kmrd_row_store and key_matrix_row_debouncer_defines.svh.
//
//   channel  | direction | handshake        | contents
//   s_*      | in        | s_tvalid/tready  | tdata: now_ms, column_sample
//   m_*      | out       | m_tvalid/tready  | tdata: row_index, row_keys, bounce, next_row
//                                             tuser: was_sampled
//   cfg_*    | in        | cfg_we           | cfg_index, cfg_data
//
// One transfer per cycle in and out unless m_tready stalls; each result is registered.
// Row state is read ahead through the registered row memory, addressed by the next row.
// Reset clears the row valid bits at once: no clearing pass, ready right away.
// s_tready drops only while a result waits and m_tready is low.
`default_nettype none
`include "key_matrix_row_debouncer_defines.svh"

module key_matrix_row_debouncer
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [15:0] now_ms, [47:16] column_sample
    input  wire logic [kmrd_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [4:0] row_index, [36:5] row_keys, [68:37] bounce_columns,
    // [73:69] next_row, [79:74] zero
    output logic [kmrd_pkg::OUT_DATA_W-1:0]           m_tdata,
    // [0] was_sampled
    output logic                                      m_tuser,
    input  wire logic                                 cfg_we,
    input  wire logic [1:0]                           cfg_index,
    input  wire logic [kmrd_pkg::COUNT_W-1:0]         cfg_data
);

    logic [kmrd_pkg::LEN_W-1:0]       debounce_length_reg;
    logic [kmrd_pkg::COUNT_W-1:0]     rows_in_use_reg;
    logic [kmrd_pkg::COUNT_W-1:0]     columns_in_use_reg;
    logic [kmrd_pkg::ROW_W-1:0]       current_row_reg;
    logic [kmrd_pkg::ROW_W-1:0]       current_row_next;
    logic                             out_valid_reg;
    logic [kmrd_pkg::OUT_DATA_W-1:0]  out_data_reg;
    logic                             out_sampled_reg;

    logic                             accept;
    logic [kmrd_pkg::TIME_W-1:0]      now_ms;
    logic [kmrd_pkg::MAX_COLUMNS-1:0] column_sample;
    kmrd_pkg::row_word_t              old_word;
    kmrd_pkg::row_word_t              new_word;
    logic [kmrd_pkg::TIME_W-1:0]      elapsed;
    kmrd_pkg::lane_ctrl_t             ctrl;
    logic [kmrd_pkg::MAX_COLUMNS-1:0] cmask;
    kmrd_pkg::lane_res_t [kmrd_pkg::MAX_COLUMNS-1:0] lanes;
    logic [kmrd_pkg::MAX_COLUMNS-1:0] row_keys;
    logic [kmrd_pkg::MAX_COLUMNS-1:0] bounce_columns;
    logic [kmrd_pkg::ROWCNT_W-1:0]    row_plus;
    logic [kmrd_pkg::ROW_W-1:0]       next_row;

    assign s_tready      = !out_valid_reg || m_tready;
    assign accept        = s_tvalid && s_tready;
    assign now_ms        = s_tdata[15:0];
    assign column_sample = kmrd_pkg::MAX_COLUMNS'(s_tdata[47:16]);

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_length_reg <= 4'd5;
            rows_in_use_reg     <= 6'd32;
            columns_in_use_reg  <= 6'd32;
        end
        else if (cfg_we)
        begin
            unique case (kmrd_pkg::cfg_index_t'(cfg_index))
                kmrd_pkg::CFG_DEBOUNCE_LENGTH:
                    debounce_length_reg <= cfg_data[kmrd_pkg::LEN_W-1:0];
                kmrd_pkg::CFG_ROWS_IN_USE:
                    rows_in_use_reg     <= cfg_data;
                kmrd_pkg::CFG_COLUMNS_IN_USE:
                    columns_in_use_reg  <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // scan control
    assign elapsed      = now_ms - old_word.stamp;
    assign ctrl.sampled = (elapsed != '0);
    assign ctrl.shifts  = (elapsed > 16'd8) ? 4'd8 : elapsed[kmrd_pkg::SHIFT_W-1:0];
    assign ctrl.lmask   = kmrd_pkg::len_mask(debounce_length_reg);
    assign cmask        = kmrd_pkg::col_mask(columns_in_use_reg);

    assign row_plus = kmrd_pkg::ROWCNT_W'(current_row_reg) + 1'b1;
    assign next_row = (row_plus >= kmrd_pkg::eff_rows(rows_in_use_reg))
                    ? '0 : kmrd_pkg::ROW_W'(row_plus);
    assign current_row_next = accept ? next_row : current_row_reg;

    kmrd_row_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (current_row_next),
        .wr_en   (accept && ctrl.sampled),
        .wr_addr (current_row_reg),
        .wr_data (new_word),
        .rd_data (old_word)
    );

    for (genvar c = 0; c < kmrd_pkg::MAX_COLUMNS; c++)
    begin : g_lane
        kmrd_lane u_lane
        (
            .ctrl       (ctrl),
            .active     (cmask[c]),
            .sample_bit (column_sample[c]),
            .hist_in    (old_word.history[c]),
            .key_in     (old_word.keys[c]),
            .res        (lanes[c])
        );
    end

    kmrd_merge u_merge
    (
        .lanes          (lanes),
        .cmask          (cmask),
        .sampled        (ctrl.sampled),
        .old_word       (old_word),
        .now_ms         (now_ms),
        .new_word       (new_word),
        .row_keys       (row_keys),
        .bounce_columns (bounce_columns)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_row_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            current_row_reg <= current_row_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {6'd0,
                             kmrd_pkg::FIELD_ROW_W'(next_row),
                             kmrd_pkg::FIELD_KEYS_W'(bounce_columns),
                             kmrd_pkg::FIELD_KEYS_W'(row_keys),
                             kmrd_pkg::FIELD_ROW_W'(current_row_reg)};
            out_sampled_reg <= ctrl.sampled;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sampled_reg;

    `KMRD_ASSERT_NEXT(a_accept_fills_output, accept, m_tvalid, "transfer left no result")
    `KMRD_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")
    `KMRD_ASSERT_NEXT(a_next_row_tracks_scan, accept,
        m_tdata[73:69] == kmrd_pkg::FIELD_ROW_W'(current_row_reg), "next_row off scan")
    `KMRD_ASSERT_NOW(a_no_bounce_unsampled, m_tvalid && !m_tuser,
        m_tdata[68:37] == '0, "bounce flagged on unsampled row")

endmodule

`default_nettype wire

// ===== src/kmrd_lane.sv =====
// One column lane: shifts the key history and classifies its newest samples.
// Depends on kmrd_pkg.
`default_nettype none

module kmrd_lane
(
    input  wire kmrd_pkg::lane_ctrl_t             ctrl,
    input  wire logic                             active,
    input  wire logic                             sample_bit,
    input  wire logic [kmrd_pkg::HIST_W-1:0]      hist_in,
    input  wire logic                             key_in,
    output kmrd_pkg::lane_res_t                   res
);

    logic [2*kmrd_pkg::HIST_W-1:0] shifted;
    logic [kmrd_pkg::HIST_W:0]     fill;
    logic [kmrd_pkg::HIST_W-1:0]   new_hist;
    logic [kmrd_pkg::HIST_W:0]     low;
    logic [kmrd_pkg::HIST_W:0]     low_bit;
    logic                          pressed;
    logic                          released;
    logic                          holding;

    assign shifted  = {{kmrd_pkg::HIST_W{1'b0}}, hist_in} << ctrl.shifts;
    assign fill     = sample_bit ? ((9'd1 << ctrl.shifts) - 9'd1) : '0;
    assign new_hist = shifted[kmrd_pkg::HIST_W-1:0] | fill[kmrd_pkg::HIST_W-1:0];
    assign low      = {1'b0, new_hist & ctrl.lmask};
    assign low_bit  = low & (~low + 9'd1);
    assign pressed  = (low != '0) && (((low + 9'd1) & low) == '0);
    assign released = (low == '0);
    assign holding  = !low[0] && ((low + low_bit) == ({1'b0, ctrl.lmask} + 9'd1));

    always_comb
    begin
        res.history = hist_in;
        res.key     = key_in;
        res.bounce  = 1'b0;
        if (ctrl.sampled && active)
        begin
            res.history = new_hist;
            if (pressed)
            begin
                res.key = 1'b1;
            end
            else if (released)
            begin
                res.key = 1'b0;
            end
            else if (!holding)
            begin
                res.bounce = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/kmrd_merge.sv =====
// Merge stage: gathers lane results into the row word and the result vectors.
// Depends on kmrd_pkg.
`default_nettype none

module kmrd_merge
(
    input  wire kmrd_pkg::lane_res_t [kmrd_pkg::MAX_COLUMNS-1:0] lanes,
    input  wire logic [kmrd_pkg::MAX_COLUMNS-1:0]                cmask,
    input  wire logic                                            sampled,
    input  wire kmrd_pkg::row_word_t                             old_word,
    input  wire logic [kmrd_pkg::TIME_W-1:0]                     now_ms,
    output kmrd_pkg::row_word_t                                  new_word,
    output logic [kmrd_pkg::MAX_COLUMNS-1:0]                     row_keys,
    output logic [kmrd_pkg::MAX_COLUMNS-1:0]                     bounce_columns
);

    logic [kmrd_pkg::MAX_COLUMNS-1:0] lane_keys;
    logic [kmrd_pkg::MAX_COLUMNS-1:0] lane_bounce;

    always_comb
    begin
        for (int c = 0; c < kmrd_pkg::MAX_COLUMNS; c++)
        begin
            new_word.history[c] = lanes[c].history;
            lane_keys[c]        = lanes[c].key;
            lane_bounce[c]      = lanes[c].bounce;
        end
        new_word.keys  = sampled ? (lane_keys & cmask) : old_word.keys;
        new_word.stamp = sampled ? now_ms : old_word.stamp;
    end

    assign row_keys       = new_word.keys & cmask;
    assign bounce_columns = sampled ? (lane_bounce & cmask) : '0;

endmodule

`default_nettype wire

// ===== src/kmrd_row_store.sv =====
// Per-row state memory: histories, debounced keys and sample time of each row.
// Registered read with write forwarding; row valid bits stand in for reset.
// Depends on kmrd_pkg.
`default_nettype none

module kmrd_row_store
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [kmrd_pkg::ROW_W-1:0]    rd_addr,
    input  wire logic                          wr_en,
    input  wire logic [kmrd_pkg::ROW_W-1:0]    wr_addr,
    input  wire kmrd_pkg::row_word_t           wr_data,
    output kmrd_pkg::row_word_t                rd_data
);

    kmrd_pkg::row_word_t           mem [kmrd_pkg::MAX_ROWS];
    kmrd_pkg::row_word_t           rd_data_reg;
    logic                          rd_valid_reg;
    logic [kmrd_pkg::MAX_ROWS-1:0] valid_reg;
    logic                          fwd;

    assign fwd = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= fwd ? wr_data : mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr] || fwd;
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire
